// ===== rtl/pfvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvs_pkg
// Shared types and constants of the potential field vector sum block.
// ----------------------------------------------------------------------------
package pfvs_pkg;

    localparam int RAD_W  = 15;   // radius and spread registers
    localparam int GAIN_W = 12;   // unsigned Q4.8 gains
    localparam int LEN_W  = 16;   // band length, at most spread + radius
    localparam int MAG_W  = GAIN_W + LEN_W;
    localparam int QUO_W  = 21;   // per-axis force magnitude, mag/256 + 1
    localparam int OUT_W  = 32;
    localparam int IDX_W  = 3;

    // saturated push of 999999 m in Q22.8
    localparam logic [29:0] PUSH_Q88 = 30'd255999744;

    typedef enum logic [IDX_W-1:0] {
        REG_GOAL_X     = 3'd0,
        REG_GOAL_Y     = 3'd1,
        REG_ATT_RADIUS = 3'd2,
        REG_ATT_SPREAD = 3'd3,
        REG_ATT_GAIN   = 3'd4,
        REG_REP_RADIUS = 3'd5,
        REG_REP_SPREAD = 3'd6,
        REG_REP_GAIN   = 3'd7
    } cfg_idx_t;

    localparam logic [RAD_W-1:0]  ATT_RADIUS_RST = 15'd282;
    localparam logic [RAD_W-1:0]  ATT_SPREAD_RST = 15'd1152;
    localparam logic [GAIN_W-1:0] ATT_GAIN_RST   = 12'd384;
    localparam logic [RAD_W-1:0]  REP_RADIUS_RST = 15'd128;
    localparam logic [RAD_W-1:0]  REP_SPREAD_RST = 15'd1024;
    localparam logic [GAIN_W-1:0] REP_GAIN_RST   = 12'd512;

endpackage

// ===== rtl/pfvs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvs_in_if / pfvs_out_if
// Valid/ready channels for obstacle items and force results.
// ----------------------------------------------------------------------------
interface pfvs_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] robot_x;
    logic signed [COORD_BITS-1:0] robot_y;
    logic signed [COORD_BITS-1:0] obstacle_x;
    logic signed [COORD_BITS-1:0] obstacle_y;
    logic                         point_valid;
    logic                         last_point;

    modport source (output valid, robot_x, robot_y, obstacle_x, obstacle_y,
                    point_valid, last_point, input ready);
    modport sink   (input valid, robot_x, robot_y, obstacle_x, obstacle_y,
                    point_valid, last_point, output ready);
endinterface

interface pfvs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pfvs_pkg::OUT_W-1:0]  force_x;
    logic signed [pfvs_pkg::OUT_W-1:0]  force_y;
    logic                               too_close;
    logic                               sum_clipped;

    modport source (output valid, force_x, force_y, too_close, sum_clipped,
                    input ready);
    modport sink   (input valid, force_x, force_y, too_close, sum_clipped,
                    output ready);
endinterface

// ===== rtl/potential_field_vector_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potential_field_vector_sum
// Repulsive obstacle forces accumulated per scan plus goal attraction.
// ----------------------------------------------------------------------------
// One item per obstacle point arrives on in_ch with the robot position.
// A valid point adds a repulsive vector to saturating sums; the item with
// last_point also adds the attractive goal vector and then puts one result
// (force_x, force_y, too_close, sum_clipped) on out_ch, after which the sums
// and flags clear.
// Each field evaluation runs bit-serially: a square root one result bit per
// cycle, then, where a force is scaled, two restoring divisions one quotient
// bit per cycle, with a shared multiplier for squares, gains and numerators.
// A point in the sloped band goes through both divisions; a saturated point
// adds the fixed push without dividing, and an out-of-range point adds
// nothing. Each item is taken in the idle state.
// The last item adds one more evaluation and the state that loads the result.
// One item is processed at a time; in_ch.ready is high only when idle.
// The result register holds a finished result while out_ch stalls; the next
// item is taken meanwhile and only the next result waits for it.
// Reset clears the sums, flags and the result register and loads the
// register defaults. cfg_wen writes register cfg_index from cfg_data.
// ----------------------------------------------------------------------------
module potential_field_vector_sum #(
    parameter int COORD_BITS = 16,
    parameter int SUM_BITS   = 32,
    localparam int CFG_W     = (COORD_BITS > pfvs_pkg::RAD_W) ? COORD_BITS
                                                               : pfvs_pkg::RAD_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [pfvs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    pfvs_in_if.sink                       in_ch,
    pfvs_out_if.source                    out_ch
);

    localparam int DW    = COORD_BITS + 1;          // offset magnitude, distance
    localparam int SQW   = 2 * DW;
    localparam int PW    = pfvs_pkg::MAG_W + DW;
    localparam int NW    = PW + 1;
    localparam int DENW  = DW + 8;
    localparam int QW    = pfvs_pkg::QUO_W;
    localparam int BW    = ((DW > pfvs_pkg::LEN_W) ? DW : pfvs_pkg::LEN_W) + 1;
    localparam int EW    = ((SUM_BITS > pfvs_pkg::OUT_W) ? SUM_BITS
                                                         : pfvs_pkg::OUT_W) + 2;
    localparam int CMAX  = (DW > QW) ? DW : QW;
    localparam int CW    = $clog2(CMAX + 1);
    localparam int OW    = pfvs_pkg::OUT_W;

    localparam logic signed [EW-1:0] SUM_MAX = EW'((64'sd1 <<< (SUM_BITS-1)) - 1);
    localparam logic signed [EW-1:0] SUM_MIN = -SUM_MAX - EW'(1);
    localparam logic signed [EW-1:0] OUT_MAX = EW'((64'sd1 <<< (OW-1)) - 1);
    localparam logic signed [EW-1:0] OUT_MIN = -OUT_MAX - EW'(1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_SQX, ST_SQY, ST_ROOT, ST_BAND, ST_MAG,
        ST_NUM, ST_DIV, ST_ACC, ST_NEXT, ST_OUT
    } state_t;

    // configuration
    logic signed [COORD_BITS-1:0]      goal_x_reg, goal_y_reg;
    logic [pfvs_pkg::RAD_W-1:0]        att_radius_reg, att_spread_reg;
    logic [pfvs_pkg::RAD_W-1:0]        rep_radius_reg, rep_spread_reg;
    logic [pfvs_pkg::GAIN_W-1:0]       att_gain_reg, rep_gain_reg;

    // item and datapath
    state_t                            state_reg;
    logic                              rep_job_reg, last_reg;
    logic signed [COORD_BITS-1:0]      rx_reg, ry_reg, ox_reg, oy_reg;
    logic [DW-1:0]                     ax_reg, ay_reg;
    logic                              sx_reg, sy_reg;
    logic [SQW-1:0]                    sq_reg;
    logic [DW:0]                       rem_reg;
    logic [DW-1:0]                     root_reg, dd_reg;
    logic [CW-1:0]                     cnt_reg;
    logic [pfvs_pkg::LEN_W-1:0]        len_reg;
    logic [pfvs_pkg::MAG_W-1:0]        mag_reg;
    logic [DENW-1:0]                   drem_reg;
    logic [QW-1:0]                     num_reg;
    logic                              axis_reg, push_reg;
    logic signed [SUM_BITS-1:0]        sum_x_reg, sum_y_reg;
    logic                              near_reg, clip_reg;

    // result register
    logic                              out_valid_reg;
    logic signed [OW-1:0]              force_x_reg, force_y_reg;
    logic                              too_close_reg, sum_clipped_reg;

    // shared multiplier
    logic [pfvs_pkg::MAG_W-1:0]        mul_a;
    logic [DW-1:0]                     mul_b;
    logic [PW-1:0]                     prod;

    always_comb
    begin
        case (state_reg)
            ST_SQX:
            begin
                mul_a = pfvs_pkg::MAG_W'(ax_reg);
                mul_b = ax_reg;
            end
            ST_SQY:
            begin
                mul_a = pfvs_pkg::MAG_W'(ay_reg);
                mul_b = ay_reg;
            end
            ST_MAG:
            begin
                mul_a = pfvs_pkg::MAG_W'(len_reg);
                mul_b = DW'(rep_job_reg ? rep_gain_reg : att_gain_reg);
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = axis_reg ? ay_reg : ax_reg;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    // offset to the target of the current evaluation
    logic signed [DW-1:0] dx, dy;
    always_comb
    begin
        if (rep_job_reg)
        begin
            dx = DW'(ox_reg) - DW'(rx_reg);
            dy = DW'(oy_reg) - DW'(ry_reg);
        end
        else
        begin
            dx = DW'(goal_x_reg) - DW'(rx_reg);
            dy = DW'(goal_y_reg) - DW'(ry_reg);
        end
    end

    // square root step
    logic [DW+2:0] sqr_t, sqr_trial;
    logic          sqr_ge;
    always_comb
    begin
        sqr_t     = {rem_reg, sq_reg[SQW-1 -: 2]};
        sqr_trial = (DW+3)'({root_reg, 2'b01});
        sqr_ge    = (sqr_t >= sqr_trial);
    end

    // band selection
    logic [BW-1:0] b_d, b_r, b_sr;
    logic          b_in_r, b_in_sr;
    logic [BW-1:0] b_len;
    always_comb
    begin
        b_d  = BW'(root_reg);
        b_r  = BW'(rep_job_reg ? rep_radius_reg : att_radius_reg);
        b_sr = b_r + BW'(rep_job_reg ? rep_spread_reg : att_spread_reg);
        b_in_r  = (b_d < b_r);
        b_in_sr = (b_d <= b_sr);
        if (rep_job_reg)
            b_len = b_sr - b_d;
        else if (b_in_sr)
            b_len = b_d - b_r;
        else
            b_len = BW'(att_spread_reg);
    end

    // numerator with half divisor for rounding
    logic [NW-1:0] numer;
    assign numer = NW'(prod) + NW'({dd_reg, 7'b0});

    // division step
    logic [DENW:0] div_t;
    logic          div_ge;
    always_comb
    begin
        div_t  = {drem_reg, num_reg[QW-1]};
        div_ge = (div_t >= (DENW+1)'({dd_reg, 8'b0}));
    end

    // accumulate step
    logic                    acc_nz, acc_neg;
    logic signed [EW-1:0]    acc_mag, acc_old, acc_sum, acc_next;
    logic                    acc_clip;
    always_comb
    begin
        acc_nz  = axis_reg ? (ay_reg != '0) : (ax_reg != '0);
        acc_neg = rep_job_reg ^ (axis_reg ? sy_reg : sx_reg);
        if (push_reg)
            acc_mag = acc_nz ? EW'(pfvs_pkg::PUSH_Q88) : '0;
        else
            acc_mag = EW'(num_reg);
        acc_old = axis_reg ? EW'(sum_y_reg) : EW'(sum_x_reg);
        acc_sum = acc_neg ? acc_old - acc_mag : acc_old + acc_mag;
        acc_clip = 1'b0;
        acc_next = acc_sum;
        if (acc_sum > SUM_MAX)
        begin
            acc_next = SUM_MAX;
            acc_clip = 1'b1;
        end
        else if (acc_sum < SUM_MIN)
        begin
            acc_next = SUM_MIN;
            acc_clip = 1'b1;
        end
    end

    // output saturation to 32 bits
    logic signed [EW-1:0] ox_w, oy_w;
    logic signed [OW-1:0] fx_next, fy_next;
    logic                 oclip;
    always_comb
    begin
        ox_w  = EW'(sum_x_reg);
        oy_w  = EW'(sum_y_reg);
        oclip = 1'b0;
        fx_next = OW'(ox_w);
        fy_next = OW'(oy_w);
        if (ox_w > OUT_MAX)
        begin
            fx_next = OW'(OUT_MAX);
            oclip = 1'b1;
        end
        else if (ox_w < OUT_MIN)
        begin
            fx_next = OW'(OUT_MIN);
            oclip = 1'b1;
        end
        if (oy_w > OUT_MAX)
        begin
            fy_next = OW'(OUT_MAX);
            oclip = 1'b1;
        end
        else if (oy_w < OUT_MIN)
        begin
            fy_next = OW'(OUT_MIN);
            oclip = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            att_radius_reg <= pfvs_pkg::ATT_RADIUS_RST;
            att_spread_reg <= pfvs_pkg::ATT_SPREAD_RST;
            att_gain_reg   <= pfvs_pkg::ATT_GAIN_RST;
            rep_radius_reg <= pfvs_pkg::REP_RADIUS_RST;
            rep_spread_reg <= pfvs_pkg::REP_SPREAD_RST;
            rep_gain_reg   <= pfvs_pkg::REP_GAIN_RST;
        end
        else if (cfg_wen)
        begin
            case (pfvs_pkg::cfg_idx_t'(cfg_index))
                pfvs_pkg::REG_GOAL_X:     goal_x_reg     <= cfg_data[COORD_BITS-1:0];
                pfvs_pkg::REG_GOAL_Y:     goal_y_reg     <= cfg_data[COORD_BITS-1:0];
                pfvs_pkg::REG_ATT_RADIUS: att_radius_reg <= cfg_data[pfvs_pkg::RAD_W-1:0];
                pfvs_pkg::REG_ATT_SPREAD: att_spread_reg <= cfg_data[pfvs_pkg::RAD_W-1:0];
                pfvs_pkg::REG_ATT_GAIN:   att_gain_reg   <= cfg_data[pfvs_pkg::GAIN_W-1:0];
                pfvs_pkg::REG_REP_RADIUS: rep_radius_reg <= cfg_data[pfvs_pkg::RAD_W-1:0];
                pfvs_pkg::REG_REP_SPREAD: rep_spread_reg <= cfg_data[pfvs_pkg::RAD_W-1:0];
                pfvs_pkg::REG_REP_GAIN:   rep_gain_reg   <= cfg_data[pfvs_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rep_job_reg     <= 1'b0;
            last_reg        <= 1'b0;
            rx_reg          <= '0;
            ry_reg          <= '0;
            ox_reg          <= '0;
            oy_reg          <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            sx_reg          <= 1'b0;
            sy_reg          <= 1'b0;
            sq_reg          <= '0;
            rem_reg         <= '0;
            root_reg        <= '0;
            dd_reg          <= '0;
            cnt_reg         <= '0;
            len_reg         <= '0;
            mag_reg         <= '0;
            drem_reg        <= '0;
            num_reg         <= '0;
            axis_reg        <= 1'b0;
            push_reg        <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            near_reg        <= 1'b0;
            clip_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            force_x_reg     <= '0;
            force_y_reg     <= '0;
            too_close_reg   <= 1'b0;
            sum_clipped_reg <= 1'b0;
        end
        else
        begin
            // ST_OUT reloads the result register itself
            if (out_valid_reg && out_ch.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        rx_reg      <= in_ch.robot_x;
                        ry_reg      <= in_ch.robot_y;
                        ox_reg      <= in_ch.obstacle_x;
                        oy_reg      <= in_ch.obstacle_y;
                        last_reg    <= in_ch.last_point;
                        rep_job_reg <= in_ch.point_valid;
                        if (in_ch.point_valid || in_ch.last_point)
                            state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    ax_reg    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
                    ay_reg    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
                    sx_reg    <= dx[DW-1];
                    sy_reg    <= dy[DW-1];
                    state_reg <= ST_SQX;
                end
                ST_SQX:
                begin
                    sq_reg    <= prod[SQW-1:0];
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    sq_reg    <= sq_reg + prod[SQW-1:0];
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    // one root bit per cycle, radicand shifts out two bits
                    sq_reg   <= {sq_reg[SQW-3:0], 2'b00};
                    if (sqr_ge)
                    begin
                        rem_reg  <= (DW+1)'(sqr_t - sqr_trial);
                        root_reg <= {root_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= (DW+1)'(sqr_t);
                        root_reg <= {root_reg[DW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(DW-1))
                        state_reg <= ST_BAND;
                end
                ST_BAND:
                begin
                    axis_reg <= 1'b0;
                    push_reg <= 1'b0;
                    len_reg  <= b_len[pfvs_pkg::LEN_W-1:0];
                    // coincident points: direction +x, distance one
                    if (root_reg == '0)
                    begin
                        ax_reg <= DW'(1);
                        ay_reg <= '0;
                        sx_reg <= 1'b0;
                        sy_reg <= 1'b0;
                        dd_reg <= DW'(1);
                    end
                    else
                        dd_reg <= root_reg;
                    if (rep_job_reg)
                    begin
                        if (b_in_r)
                        begin
                            near_reg  <= 1'b1;
                            push_reg  <= 1'b1;
                            state_reg <= ST_ACC;
                        end
                        else if (b_in_sr)
                            state_reg <= ST_MAG;
                        else
                            state_reg <= ST_NEXT;
                    end
                    else if (b_in_r)
                        state_reg <= ST_NEXT;
                    else
                        state_reg <= ST_MAG;
                end
                ST_MAG:
                begin
                    mag_reg   <= prod[pfvs_pkg::MAG_W-1:0];
                    state_reg <= ST_NUM;
                end
                ST_NUM:
                begin
                    drem_reg  <= numer[NW-1:QW];
                    num_reg   <= numer[QW-1:0];
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // quotient bits shift in as numerator bits shift out
                    if (div_ge)
                        drem_reg <= DENW'(div_t - (DENW+1)'({dd_reg, 8'b0}));
                    else
                        drem_reg <= DENW'(div_t);
                    num_reg <= {num_reg[QW-2:0], div_ge};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(QW-1))
                        state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (axis_reg)
                        sum_y_reg <= SUM_BITS'(acc_next);
                    else
                        sum_x_reg <= SUM_BITS'(acc_next);
                    if (acc_clip)
                        clip_reg <= 1'b1;
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= push_reg ? ST_ACC : ST_NUM;
                    end
                    else
                        state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (!rep_job_reg)
                        state_reg <= ST_OUT;
                    else if (last_reg)
                    begin
                        rep_job_reg <= 1'b0;
                        state_reg   <= ST_SETUP;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        force_x_reg     <= fx_next;
                        force_y_reg     <= fy_next;
                        too_close_reg   <= near_reg;
                        sum_clipped_reg <= clip_reg | oclip;
                        sum_x_reg       <= '0;
                        sum_y_reg       <= '0;
                        near_reg        <= 1'b0;
                        clip_reg        <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.force_x     = force_x_reg;
    assign out_ch.force_y     = force_y_reg;
    assign out_ch.too_close   = too_close_reg;
    assign out_ch.sum_clipped = sum_clipped_reg;

endmodule
